// ----- sv/hann_real_fft_power_spectrum_macros.svh -----
// Assertion macros used by the power spectrum RTL.
`ifndef HANN_REAL_FFT_POWER_SPECTRUM_MACROS_SVH
`define HANN_REAL_FFT_POWER_SPECTRUM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define HRPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrps: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define HRPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrps: next-cycle check failed");
`else
`define HRPS_ASSERT_IMP(lbl, ante, cons)
`define HRPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/hrps_pkg.sv -----
// Shared constants, types and cosine table for the power spectrum block.
package hrps_pkg;

	localparam int FRAME_SIZE_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int COEF_W          = 17;
	localparam int POWER_W         = 48;
	localparam int INDEX_W         = 6;
	localparam int TW_W            = 6;
	localparam int STAGE_W         = 3;

	// Buffer access controls from the sequencer.
	typedef struct packed {
		logic wr_re;
		logic wr_im;
		logic rd;
	} hrps_mem_ctl_t;

	// First quarter of a 64-point cosine in Q1.15, full scale held at 32767.
	function automatic logic signed [COEF_W-1:0] quarter_cos(input logic [4:0] i);
		logic signed [COEF_W-1:0] v;
		case (i)
			5'd0:    v = 17'sd32767;
			5'd1:    v = 17'sd32610;
			5'd2:    v = 17'sd32138;
			5'd3:    v = 17'sd31357;
			5'd4:    v = 17'sd30274;
			5'd5:    v = 17'sd28899;
			5'd6:    v = 17'sd27246;
			5'd7:    v = 17'sd25330;
			5'd8:    v = 17'sd23170;
			5'd9:    v = 17'sd20788;
			5'd10:   v = 17'sd18205;
			5'd11:   v = 17'sd15447;
			5'd12:   v = 17'sd12540;
			5'd13:   v = 17'sd9512;
			5'd14:   v = 17'sd6393;
			5'd15:   v = 17'sd3212;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

	// Cosine of 2*pi*k/64 built from the quarter table by symmetry.
	function automatic logic signed [COEF_W-1:0] cos64(input logic [TW_W-1:0] k);
		logic signed [COEF_W-1:0] v;
		case (k) inside
			[6'd0:6'd16]:  v = quarter_cos(5'(k));
			[6'd17:6'd32]: v = -quarter_cos(5'(6'd32 - k));
			[6'd33:6'd48]: v = -quarter_cos(5'(k - 6'd32));
			default:       v = quarter_cos(5'(6'd0 - k));
		endcase
		return v;
	endfunction

	// Sine read as the cosine a quarter turn back.
	function automatic logic signed [COEF_W-1:0] sin64(input logic [TW_W-1:0] k);
		return cos64(k + 6'd48);
	endfunction

endpackage

// ----- sv/hrps_buf.sv -----
// Work buffer: real and imaginary halves, one write port, two registered read ports.
module hrps_buf import hrps_pkg::*; #(
	parameter int DEPTH = FRAME_SIZE_DEF / 2,
	parameter int AW    = $clog2(FRAME_SIZE_DEF / 2)
) (
	input  logic                     clk,
	input  hrps_mem_ctl_t            ctl,
	input  logic [AW-1:0]            wr_addr,
	input  logic signed [DATA_W-1:0] wr_re_data,
	input  logic signed [DATA_W-1:0] wr_im_data,
	input  logic [AW-1:0]            rd_addr_a,
	input  logic [AW-1:0]            rd_addr_b,
	output logic signed [DATA_W-1:0] a_re,
	output logic signed [DATA_W-1:0] a_im,
	output logic signed [DATA_W-1:0] b_re,
	output logic signed [DATA_W-1:0] b_im
);

	logic signed [DATA_W-1:0] mem_re [DEPTH];
	logic signed [DATA_W-1:0] mem_im [DEPTH];

	// Writes to either half.
	always_ff @(posedge clk) begin
		if (ctl.wr_re) begin
			mem_re[wr_addr] <= wr_re_data;
		end
		if (ctl.wr_im) begin
			mem_im[wr_addr] <= wr_im_data;
		end
	end

	// Registered reads at two addresses; data holds between reads.
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			a_re <= mem_re[rd_addr_a];
			a_im <= mem_im[rd_addr_a];
			b_re <= mem_re[rd_addr_b];
			b_im <= mem_im[rd_addr_b];
		end
	end

endmodule

// ----- sv/hann_real_fft_power_spectrum.sv -----
// Top level: Hann window, in-place radix-2 FFT and power spectrum sequencer.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  sample
//   out      from block out_valid / out_stall bin_power, bin_index, last_bin
//
// The block takes samples whenever it is idle. After the last sample of a frame
// each butterfly passes ST_B_RD, ST_B_MUL, ST_B_WA and ST_B_WB on the single
// butterfly unit, (FRAME_SIZE/4)*log2(FRAME_SIZE/2) butterflies in all.
// Each bin then passes through the unpack and squaring steps ST_U_RD, ST_U_MUL,
// ST_U_SUM, ST_U_SQ and ST_U_OUT in order; a stalled output holds the sequencer.
// Reset clears the sample count, the sequencer and the output valid; the buffer
// needs no clearing because every entry is written before the transform reads it.
`include "hann_real_fft_power_spectrum_macros.svh"
module hann_real_fft_power_spectrum import hrps_pkg::*; #(
	parameter int FRAME_SIZE  = FRAME_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [POWER_W-1:0]            bin_power,
	output logic [INDEX_W-1:0]            bin_index,
	output logic                          last_bin
);

	localparam int HALF     = FRAME_SIZE / 2;
	localparam int AW       = $clog2(HALF);
	localparam int CW       = $clog2(FRAME_SIZE);
	localparam int BW       = (AW > 1) ? AW - 1 : 1;
	localparam int NBF      = HALF / 2;
	localparam int ROM_STEP = 64 / FRAME_SIZE;
	localparam int TAPW     = SAMPLE_BITS + 18;
	localparam int MAGW     = 36;
	localparam int SUMW     = 74;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_RD,
		ST_B_MUL,
		ST_B_WA,
		ST_B_WB,
		ST_U_RD,
		ST_U_MUL,
		ST_U_SUM,
		ST_U_SQ,
		ST_U_OUT
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [STAGE_W-1:0]     stage_q;
	logic [BW-1:0]          bf_q;
	logic [AW:0]            k_q;
	logic                   out_valid_q;
	logic [POWER_W-1:0]     bin_power_q;
	logic [INDEX_W-1:0]     bin_index_q;
	logic                   last_bin_q;

	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	hrps_mem_ctl_t          mem_ctl;
	logic [AW-1:0]          wr_addr;
	logic signed [DATA_W-1:0] wr_re_data;
	logic signed [DATA_W-1:0] wr_im_data;
	logic [AW-1:0]          rd_addr_a;
	logic [AW-1:0]          rd_addr_b;
	logic signed [DATA_W-1:0] ra_re, ra_im, rb_re, rb_im;

	// Window and sample position.
	logic signed [COEF_W-1:0] win_cos;
	logic signed [17:0]       win_diff;
	logic signed [COEF_W-1:0] win;
	logic signed [TAPW-1:0]   tap_full;
	logic signed [DATA_W-1:0] tap;
	logic [AW-1:0]            half_idx;
	logic [AW-1:0]            pos;

	// Butterfly addressing and coefficients.
	logic [AW-1:0]            hm;
	logic [AW-1:0]            bfx;
	logic [AW-1:0]            ia;
	logic [AW-1:0]            ib;
	logic [TW_W-1:0]          tw_idx;
	logic [TW_W-1:0]          uk_idx;
	logic [TW_W-1:0]          coef_idx;
	logic signed [COEF_W-1:0] co_c;
	logic signed [COEF_W-1:0] co_s;

	// Butterfly datapath registers.
	logic signed [48:0]       p_cbr_q, p_sbi_q, p_cbi_q, p_sbr_q;
	logic signed [49:0]       tr_sum, ti_sum, tr, ti;
	logic signed [DATA_W-1:0] b_re_q, b_im_q;

	// Unpack datapath.
	logic signed [17:0]       u_ps, u_ms, u_sm;
	logic signed [32:0]       u_aibi, u_arbr;
	logic signed [49:0]       q1_q, q2_q, q3_q, q4_q, q5_q, q6_q;
	logic signed [32:0]       u_sp_q;
	logic                     u_special_q;
	logic signed [51:0]       re_sum, im_sum;
	logic signed [MAGW-1:0]   re_v, im_v;
	logic [MAGW-1:0]          re_mag, im_mag;
	logic [17:0]              re_hi_q, re_lo_q, im_hi_q, im_lo_q;
	logic [35:0]              rhh_q, rhl_q, rll_q, ihh_q, ihl_q, ill_q;
	logic [SUMW-1:0]          tot, tot_sc;
	logic [POWER_W-1:0]       power_sat;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_U_OUT) && out_free;

	// Hann window tap for the incoming sample.
	always_comb begin
		win_cos  = cos64(TW_W'(int'(count_q) * ROM_STEP));
		win_diff = 18'sd32768 - 18'(win_cos);
		win      = COEF_W'(win_diff >>> 1);
		tap_full = TAPW'(sample) * TAPW'(win) + TAPW'(16384);
		tap      = DATA_W'(tap_full >>> 15);
		half_idx = count_q[CW-1:1];
		for (int i = 0; i < AW; i++) begin
			pos[i] = half_idx[AW-1-i];
		end
	end

	// Butterfly addresses and twiddle index for the current stage, the unpack index and the coefficients.
	always_comb begin
		hm       = (AW'(1) << stage_q) - AW'(1);
		bfx      = AW'(bf_q);
		ia       = ((bfx & ~hm) << 1) | (bfx & hm);
		ib       = ia | (AW'(1) << stage_q);
		tw_idx   = TW_W'(bfx & hm) << (STAGE_W'(5) - stage_q);
		uk_idx   = TW_W'(int'(k_q) * ROM_STEP);
		coef_idx = (state_q == ST_B_MUL) ? tw_idx : uk_idx;
		co_c     = cos64(coef_idx);
		co_s     = sin64(coef_idx);
	end

	// Buffer port selection.
	always_comb begin
		mem_ctl    = '0;
		wr_addr    = pos;
		wr_re_data = tap;
		wr_im_data = tap;
		rd_addr_a  = ia;
		rd_addr_b  = ib;
		case (state_q)
			ST_IDLE: begin
				mem_ctl.wr_re = in_acc && !count_q[0];
				mem_ctl.wr_im = in_acc && count_q[0];
			end
			ST_B_RD: begin
				mem_ctl.rd = 1'b1;
			end
			ST_B_WA: begin
				mem_ctl.wr_re = 1'b1;
				mem_ctl.wr_im = 1'b1;
				wr_addr       = ia;
				wr_re_data    = DATA_W'(50'(ra_re) + tr);
				wr_im_data    = DATA_W'(50'(ra_im) + ti);
			end
			ST_B_WB: begin
				mem_ctl.wr_re = 1'b1;
				mem_ctl.wr_im = 1'b1;
				wr_addr       = ib;
				wr_re_data    = b_re_q;
				wr_im_data    = b_im_q;
			end
			ST_U_RD: begin
				mem_ctl.rd = 1'b1;
				rd_addr_a  = k_q[AW-1:0];
				rd_addr_b  = AW'(0) - k_q[AW-1:0];
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// Butterfly rounding of the twiddled product.
	always_comb begin
		tr_sum = 50'(p_cbr_q) - 50'(p_sbi_q) + 50'sd16384;
		ti_sum = 50'(p_cbi_q) + 50'(p_sbr_q) + 50'sd16384;
		tr     = tr_sum >>> 15;
		ti     = ti_sum >>> 15;
	end

	// Unpack terms, rounding, magnitudes and the final power.
	always_comb begin
		u_ps   = 18'sd32768 + 18'(co_s);
		u_ms   = 18'sd32768 - 18'(co_s);
		u_sm   = -u_ms;
		u_aibi = 33'(ra_im) + 33'(rb_im);
		u_arbr = 33'(ra_re) - 33'(rb_re);
		re_sum = 52'(q1_q) + 52'(q2_q) + 52'(q3_q) + 52'sd32768;
		im_sum = 52'(q4_q) + 52'(q5_q) - 52'(q6_q) + 52'sd32768;
		re_v   = u_special_q ? MAGW'(u_sp_q) : MAGW'(re_sum >>> 16);
		im_v   = u_special_q ? '0 : MAGW'(im_sum >>> 16);
		re_mag = re_v[MAGW-1] ? MAGW'(-re_v) : MAGW'(re_v);
		im_mag = im_v[MAGW-1] ? MAGW'(-im_v) : MAGW'(im_v);
		tot    = (SUMW'(rhh_q) << 36) + (SUMW'(rhl_q) << 19) + SUMW'(rll_q)
			+ (SUMW'(ihh_q) << 36) + (SUMW'(ihl_q) << 19) + SUMW'(ill_q);
		tot_sc = (k_q == (AW+1)'(HALF)) ? (tot >> 2) : tot;
		power_sat = (|tot_sc[SUMW-1:POWER_W]) ? '1 : tot_sc[POWER_W-1:0];
	end

	// Sequencer, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			stage_q     <= '0;
			bf_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (count_q == CW'(FRAME_SIZE - 1)) begin
							count_q <= '0;
							stage_q <= '0;
							bf_q    <= '0;
							state_q <= ST_B_RD;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_B_RD:  state_q <= ST_B_MUL;
				ST_B_MUL: state_q <= ST_B_WA;
				ST_B_WA:  state_q <= ST_B_WB;
				ST_B_WB: begin
					if (bf_q == BW'(NBF - 1)) begin
						bf_q <= '0;
						if (stage_q == STAGE_W'(AW - 1)) begin
							k_q     <= '0;
							state_q <= ST_U_RD;
						end else begin
							stage_q <= stage_q + STAGE_W'(1);
							state_q <= ST_B_RD;
						end
					end else begin
						bf_q    <= bf_q + BW'(1);
						state_q <= ST_B_RD;
					end
				end
				ST_U_RD:  state_q <= ST_U_MUL;
				ST_U_MUL: state_q <= ST_U_SUM;
				ST_U_SUM: state_q <= ST_U_SQ;
				ST_U_SQ:  state_q <= ST_U_OUT;
				ST_U_OUT: begin
					if (out_free) begin
						bin_power_q <= power_sat;
						bin_index_q <= INDEX_W'(k_q);
						last_bin_q  <= (k_q == (AW+1)'(HALF));
						if (k_q == (AW+1)'(HALF)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + (AW+1)'(1);
							state_q <= ST_U_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic registers of the butterfly and unpack steps.
	always_ff @(posedge clk) begin
		if (state_q == ST_B_MUL) begin
			p_cbr_q <= 49'(co_c) * 49'(rb_re);
			p_sbi_q <= 49'(co_s) * 49'(rb_im);
			p_cbi_q <= 49'(co_c) * 49'(rb_im);
			p_sbr_q <= 49'(co_s) * 49'(rb_re);
		end
		if (state_q == ST_B_WA) begin
			b_re_q <= DATA_W'(50'(ra_re) - tr);
			b_im_q <= DATA_W'(50'(ra_im) - ti);
		end
		if (state_q == ST_U_MUL) begin
			q1_q        <= 50'(ra_re) * 50'(u_ps);
			q2_q        <= 50'(rb_re) * 50'(u_ms);
			q3_q        <= 50'(co_c) * 50'(u_aibi);
			q4_q        <= 50'(ra_im) * 50'(u_ps);
			q5_q        <= 50'(rb_im) * 50'(u_sm);
			q6_q        <= 50'(co_c) * 50'(u_arbr);
			u_sp_q      <= (k_q == '0) ? (33'(ra_re) + 33'(ra_im))
			                           : (33'(ra_re) - 33'(ra_im));
			u_special_q <= (k_q == '0) || (k_q == (AW+1)'(HALF));
		end
		if (state_q == ST_U_SUM) begin
			re_hi_q <= re_mag[35:18];
			re_lo_q <= re_mag[17:0];
			im_hi_q <= im_mag[35:18];
			im_lo_q <= im_mag[17:0];
		end
		if (state_q == ST_U_SQ) begin
			rhh_q <= re_hi_q * re_hi_q;
			rhl_q <= re_hi_q * re_lo_q;
			rll_q <= re_lo_q * re_lo_q;
			ihh_q <= im_hi_q * im_hi_q;
			ihl_q <= im_hi_q * im_lo_q;
			ill_q <= im_lo_q * im_lo_q;
		end
	end

	hrps_buf #(
		.DEPTH (HALF),
		.AW    (AW)
	) u_buf (
		.clk        (clk),
		.ctl        (mem_ctl),
		.wr_addr    (wr_addr),
		.wr_re_data (wr_re_data),
		.wr_im_data (wr_im_data),
		.rd_addr_a  (rd_addr_a),
		.rd_addr_b  (rd_addr_b),
		.a_re       (ra_re),
		.a_im       (ra_im),
		.b_re       (rb_re),
		.b_im       (rb_im)
	);

	assign out_valid = out_valid_q;
	assign bin_power = bin_power_q;
	assign bin_index = bin_index_q;
	assign last_bin  = last_bin_q;

	// The sample count rests at zero while a frame is being transformed.
	`HRPS_ASSERT_IMP(a_count_idle, state_q != ST_IDLE, count_q == '0)
	// The final sample of a frame starts the transform.
	`HRPS_ASSERT_NXT(a_frame_start, in_acc && (count_q == CW'(FRAME_SIZE - 1)), state_q == ST_B_RD)
	// The final bin always carries the top index.
	`HRPS_ASSERT_IMP(a_last_index, out_valid_q && last_bin_q, bin_index_q == INDEX_W'(HALF))
	// While an earlier bin waits, the spectrum is not finished.
	`HRPS_ASSERT_IMP(a_busy_bins, out_valid_q && !last_bin_q, state_q != ST_IDLE)

endmodule

// ----- tb/tb_hann_real_fft_power_spectrum.sv -----
// Self-checking testbench for the Hann-windowed real FFT power spectrum block.
module tb_hann_real_fft_power_spectrum;
	import hrps_pkg::*;

	localparam int N_SAMP   = 64;
	localparam int N_HALF   = N_SAMP / 2;
	localparam int N_BINS   = N_HALF + 1;
	localparam int LIMIT    = 400000;
	localparam int HOLD_LEN = 1500;

	// One bin of the spectrum as the block reports it.
	typedef struct {
		logic [POWER_W-1:0] power;
		logic [INDEX_W-1:0] index;
		logic               last;
	} spec_bin_t;

	// Frame accumulator, fixed-point transform and store of pending bins.
	class spectrum_board;
		spec_bin_t pending[$];
		int        buf_re[N_HALF];
		int        buf_im[N_HALF];
		int        fill;
		int        errors;
		int        bins_seen;
		int        frames_done;

		function new();
			fill = 0;
			errors = 0;
			bins_seen = 0;
			frames_done = 0;
			foreach (buf_re[i]) begin
				buf_re[i] = 0;
				buf_im[i] = 0;
			end
		endfunction

		// Q1.15 cosine of 2*pi*k/64, full scale held at 32767.
		function longint cos_q15(int k);
			int q[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
				20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
			int m;
			m = k & 63;
			if (m <= 16) return q[m];
			if (m <= 32) return -q[32 - m];
			if (m <= 48) return -q[m - 32];
			return q[64 - m];
		endfunction

		function longint sin_q15(int k);
			return cos_q15(k + 48);
		endfunction

		// Round to nearest, ties upward, by an arithmetic shift.
		function longint round_down(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function int rev5(int p);
			int r;
			r = 0;
			for (int b = 0; b < 5; b++)
				if (p[b]) r[4 - b] = 1'b1;
			return r;
		endfunction

		function longint unsigned mag2(longint v);
			longint unsigned a;
			a = (v < 0) ? longint'(-v) : v;
			return a * a;
		endfunction

		function void push_bin(int k, longint unsigned pw);
			spec_bin_t e;
			if (pw > 64'hFFFF_FFFF_FFFF) pw = 64'hFFFF_FFFF_FFFF;
			e.power = pw[POWER_W-1:0];
			e.index = k[INDEX_W-1:0];
			e.last  = (k == N_HALF);
			pending.push_back(e);
		endfunction

		// In-place radix-2 decimation-in-time transform without stage scaling.
		function void transform();
			longint c, s, br, bi, tr, ti, ar, ai;
			int ia, ib;
			for (int span = 2; span <= N_HALF; span *= 2)
				for (int base = 0; base < N_HALF; base += span)
					for (int j = 0; j < span / 2; j++) begin
						ia = base + j;
						ib = ia + span / 2;
						c  = cos_q15(j * (64 / span));
						s  = sin_q15(j * (64 / span));
						br = buf_re[ib];
						bi = buf_im[ib];
						tr = round_down(c * br - s * bi, 15);
						ti = round_down(c * bi + s * br, 15);
						ar = buf_re[ia];
						ai = buf_im[ia];
						buf_re[ia] = int'(ar + tr);
						buf_im[ia] = int'(ai + ti);
						buf_re[ib] = int'(ar - tr);
						buf_im[ib] = int'(ai - ti);
					end
		endfunction

		// Notes one accepted sample; the last one of a frame yields all bins.
		function void note_sample(logic [15:0] raw);
			longint x, w, tap, c, s, ar, ai, br, bi, re, im;
			int pos, m;
			x   = longint'($signed(raw));
			w   = (32768 - cos_q15(fill)) >>> 1;
			tap = round_down(x * w, 15);
			pos = rev5(fill >> 1);
			if (fill & 1) buf_im[pos] = int'(tap);
			else buf_re[pos] = int'(tap);
			if (fill < N_SAMP - 1) begin
				fill++;
				return;
			end
			fill = 0;
			frames_done++;
			transform();
			push_bin(0, mag2(longint'(buf_re[0]) + buf_im[0]));
			for (int k = 1; k < N_HALF; k++) begin
				m  = N_HALF - k;
				c  = cos_q15(k);
				s  = sin_q15(k);
				ar = buf_re[k];
				ai = buf_im[k];
				br = buf_re[m];
				bi = buf_im[m];
				re = round_down(ar * (32768 + s) + br * (32768 - s) + c * (ai + bi), 16);
				im = round_down(ai * (32768 + s) + bi * (s - 32768) - c * (ar - br), 16);
				push_bin(k, mag2(re) + mag2(im));
			end
			push_bin(N_HALF, mag2(longint'(buf_re[0]) - buf_im[0]) >> 2);
		endfunction

		// Compares one delivered bin with the oldest pending one.
		function void check_bin(logic [POWER_W-1:0] pw, logic [INDEX_W-1:0] idx, logic lst);
			spec_bin_t e;
			bins_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected bin %0d power %0d", $time, idx, pw);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (pw !== e.power) begin
				$display("%0t: bin_power expected %0d actual %0d", $time, e.power, pw);
				errors++;
			end
			if (idx !== e.index) begin
				$display("%0t: bin_index expected %0d actual %0d", $time, e.index, idx);
				errors++;
			end
			if (lst !== e.last) begin
				$display("%0t: last_bin expected %0d actual %0d", $time, e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic signed [15:0]  sample;
	logic                out_valid;
	logic                out_stall;
	logic [POWER_W-1:0]  bin_power;
	logic [INDEX_W-1:0]  bin_index;
	logic                last_bin;

	spectrum_board board;
	int                  cycles;
	int                  burst_left;
	int                  stall_pct;
	bit                  hold_done;

	hann_real_fft_power_spectrum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_power (bin_power),
		.bin_index (bin_index),
		.last_bin  (last_bin)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle count and timeout.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stall pattern, one long hold-off during the first spectrum.
	initial begin
		int hold_cnt;
		out_stall = 1'b0;
		stall_pct = 0;
		hold_done = 1'b0;
		hold_cnt  = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && board != null && board.bins_seen >= 10) begin
				out_stall <= 1'b1;
				hold_cnt++;
				if (hold_cnt == HOLD_LEN) hold_done = 1'b1;
			end else begin
				if (cycles % 64 == 0) begin
					case ($urandom_range(0, 2))
						0: stall_pct = 0;
						1: stall_pct = 30;
						default: stall_pct = 75;
					endcase
				end
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Check every bin that the block delivers.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_bin(bin_power, bin_index, last_bin);

	// Offers one sample, waits until the block takes it; samples come in bursts.
	task automatic send_sample(logic [15:0] v);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_sample(v);
	endtask

	// One frame of random or fixed content in a chosen style.
	task automatic send_frame(int style);
		logic [15:0] v;
		for (int i = 0; i < N_SAMP; i++) begin
			case (style)
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(0, 255) - 128);
				2: v = (i & 1) ? 16'h8000 : 16'h7FFF;
				3: v = 16'h7FFF;
				default: v = (i < N_SAMP / 2) ? 16'h8000 : 16'($urandom);
			endcase
			send_sample(v);
		end
	endtask

	// Stimulus and end of run.
	initial begin
		logic [15:0] edge_vals[8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
			16'hFFFF, 16'h5555, 16'hAAAA, 16'h8001};
		int drain;
		board      = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample     = '0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frame: extreme values first, then random fill.
		for (int i = 0; i < N_SAMP; i++)
			send_sample(i < 24 ? edge_vals[i % 8] : 16'($urandom));
		// A full-scale alternating frame, then one frame in a random style.
		send_frame(2);
		send_frame($urandom_range(0, 4));
		@(negedge clk);
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		drain = 0;
		while (drain < 400) begin
			@(posedge clk);
			drain++;
		end
		$display("Covered %0d frames and %0d bins, with random gaps, stalls and a long hold-off.",
			board.frames_done, board.bins_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
